/* rtl/heater_adc_average_pi_control_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the heater ADC average and PI control block
// Concurrent assertion wrappers that vanish from synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HEATER_ADC_AVERAGE_PI_CONTROL_ASSERT_SVH
`define HEATER_ADC_AVERAGE_PI_CONTROL_ASSERT_SVH

`ifndef SYNTHESIS
`define HAPC_ASSERT_SAME(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("hapc: same-cycle check failed");
`define HAPC_ASSERT_NEXT(label, clock, resetn, ante, cons) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("hapc: next-cycle check failed");
`else
`define HAPC_ASSERT_SAME(label, clock, resetn, ante, cons)
`define HAPC_ASSERT_NEXT(label, clock, resetn, ante, cons)
`endif

`endif

/* rtl/hapc_pkg.sv */
// ----------------------------------------------------------------------------
// hapc_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package hapc_pkg;

    localparam int AVERAGE_DEPTH = 4;
    localparam int RING_SIZE     = 3 * AVERAGE_DEPTH;
    localparam int POS_W         = $clog2(RING_SIZE);
    localparam int SUM_W         = $clog2(AVERAGE_DEPTH * 1023 + 1);
    localparam int CNT_W         = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TARGET   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KI       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KP       = 2'd2;

    localparam logic [15:0] GAIN_RESET   = 16'd256;
    localparam int          TIP_MULT     = 113;
    localparam int          CURRENT_MULT = 113;
    localparam int          SUPPLY_MULT  = 629;
    localparam int          DIV5_RECIP   = 52429;
    localparam int          DIV125_RECIP = 8389;
    localparam int          CURRENT_MAX  = 1023;
    localparam int          SUPPLY_MAX   = 63;
    localparam int          POWER_MAX    = 31;

    typedef enum logic [1:0] {
        CH_TIP     = 2'd0,
        CH_CURRENT = 2'd1,
        CH_SUPPLY  = 2'd2
    } channel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PI_MUL,
        ST_PI_INT,
        ST_PI_OUT,
        ST_SUM,
        ST_SCALE,
        ST_DIVIDE,
        ST_POWER_MUL,
        ST_POWER_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic pi_mul;
        logic pi_int;
        logic pi_out;
        logic acc_step;
        logic scale;
        logic divide;
        logic power_mul;
        logic power_div;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        channel_t channel;
        logic     acc_last;
    } status_t;

endpackage

`default_nettype wire

/* rtl/heater_adc_average_pi_control.sv */
// Once a word is accepted the sequencer runs the PI multiply, integrate and output
// steps, then on the current and supply channels the 4-step channel sum over the
// sample ring's single read port, then scale, divide, power multiply, power divide
// and finish; the tip channel skips the sum. No new word is taken until the last has
// left finish, which waits while the output is stalled. Reset clears the sample
// ring, held values and integrator, resets the config registers and idles the block.
// ----------------------------------------------------------------------------
// heater_adc_average_pi_control
// Moving-average ADC front end with a saturating PI temperature loop.
// ----------------------------------------------------------------------------
`default_nettype none

module heater_adc_average_pi_control (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [hapc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hapc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [9:0]                          adc_sample,
    input  wire logic signed [7:0]                   board_temperature,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [1:0]                               channel,
    output logic signed [23:0]                       heater_drive,
    output logic signed [11:0]                       tip_temperature,
    output logic [9:0]                               heater_current,
    output logic [5:0]                               supply_level,
    output logic [4:0]                               heater_power
);

    hapc_pkg::cmd_t    cmd;
    hapc_pkg::status_t status;

    hapc_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    hapc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .adc_sample        (adc_sample),
        .board_temperature (board_temperature),
        .cmd               (cmd),
        .status            (status),
        .channel           (channel),
        .heater_drive      (heater_drive),
        .tip_temperature   (tip_temperature),
        .heater_current    (heater_current),
        .supply_level      (supply_level),
        .heater_power      (heater_power)
    );

endmodule

`default_nettype wire

/* rtl/hapc_datapath.sv */
// ----------------------------------------------------------------------------
// hapc_datapath
// Sample ring, channel averaging and scaling, PI arithmetic and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hapc_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [hapc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [hapc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic [9:0]                          adc_sample,
    input  wire logic signed [7:0]                   board_temperature,
    input  wire hapc_pkg::cmd_t                      cmd,
    output hapc_pkg::status_t                        status,
    output logic [1:0]                               channel,
    output logic signed [23:0]                       heater_drive,
    output logic signed [11:0]                       tip_temperature,
    output logic [9:0]                               heater_current,
    output logic [5:0]                               supply_level,
    output logic [4:0]                               heater_power
);

    localparam int POS_W = hapc_pkg::POS_W;
    localparam int SUM_W = hapc_pkg::SUM_W;
    localparam int CNT_W = hapc_pkg::CNT_W;

    logic [9:0]                 target_reg;
    logic [15:0]                ki_reg;
    logic [15:0]                kp_reg;

    logic [9:0]                 ring_reg [hapc_pkg::RING_SIZE];
    logic [POS_W-1:0]           pos_reg;
    hapc_pkg::channel_t         ch_pos_reg;
    hapc_pkg::channel_t         channel_reg;
    logic [9:0]                 adc_reg;
    logic signed [7:0]          board_reg;

    logic signed [11:0]         held_tip_reg;
    logic signed [31:0]         integ_reg;
    logic [9:0]                 held_current_reg;
    logic [5:0]                 held_supply_reg;

    logic signed [29:0]         prod_i_reg;
    logic signed [29:0]         prod_p_reg;
    logic signed [23:0]         drive_reg;
    logic [SUM_W-1:0]           acc_reg;
    logic [POS_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [SUM_W-1:0]           scaled_reg;
    logic [15:0]                pprod_reg;
    logic [4:0]                 power_reg;

    logic [1:0]                 out_channel_reg;
    logic signed [23:0]         out_drive_reg;
    logic signed [11:0]         out_tip_reg;
    logic [9:0]                 out_current_reg;
    logic [5:0]                 out_supply_reg;
    logic [4:0]                 out_power_reg;

    logic [POS_W-1:0]           pos_next;
    hapc_pkg::channel_t         ch_pos_next;
    logic signed [12:0]         err;
    logic signed [29:0]         prod_i_next;
    logic signed [29:0]         prod_p_next;
    logic signed [32:0]         integ_sum;
    logic signed [31:0]         integ_next;
    logic signed [32:0]         pi_sum;
    logic signed [32:0]         pi_biased;
    logic signed [24:0]         pi_quot;
    logic signed [23:0]         drive_next;
    logic [16:0]                tip_mul;
    logic signed [11:0]         tip_next;
    logic [SUM_W+6:0]           cur_mul;
    logic [SUM_W+9:0]           sup_mul;
    logic [SUM_W-1:0]           scaled_next;
    logic [SUM_W+15:0]          div5_mul;
    logic [31:0]                cur_wide;
    logic [31:0]                sup_wide;
    logic [26:0]                div125_mul;
    logic [6:0]                 power_wide;
    logic [SUM_W-1:0]           acc_next;

    always_comb
    begin
        if (pos_reg == POS_W'(hapc_pkg::RING_SIZE - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        unique case (ch_pos_reg)
            hapc_pkg::CH_TIP:     ch_pos_next = hapc_pkg::CH_CURRENT;
            hapc_pkg::CH_CURRENT: ch_pos_next = hapc_pkg::CH_SUPPLY;
            default:              ch_pos_next = hapc_pkg::CH_TIP;
        endcase
    end

    always_comb
    begin
        err         = $signed({3'b000, target_reg}) - {held_tip_reg[11], held_tip_reg};
        prod_i_next = $signed({1'b0, ki_reg}) * err;
        prod_p_next = $signed({1'b0, kp_reg}) * err;

        integ_sum = {integ_reg[31], integ_reg} + {{3{prod_i_reg[29]}}, prod_i_reg};
        if (integ_sum[32] != integ_sum[31])
        begin
            integ_next = integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            integ_next = integ_sum[31:0];
        end

        pi_sum    = {integ_reg[31], integ_reg} + {{3{prod_p_reg[29]}}, prod_p_reg};
        pi_biased = pi_sum + (pi_sum[32] ? 33'sd255 : 33'sd0);
        pi_quot   = pi_biased[32:8];
        if (pi_quot[24] != pi_quot[23])
        begin
            drive_next = pi_quot[24] ? 24'sh80_0000 : 24'sh7F_FFFF;
        end
        else
        begin
            drive_next = pi_quot[23:0];
        end
    end

    always_comb
    begin
        tip_mul  = {7'b0, adc_reg} * 17'(hapc_pkg::TIP_MULT);
        tip_next = $signed({2'b00, tip_mul[16:7]}) + {{4{board_reg[7]}}, board_reg};

        acc_next = acc_reg + SUM_W'(ring_reg[rd_ptr_reg]);

        cur_mul = {7'b0, acc_reg} * (SUM_W+7)'(hapc_pkg::CURRENT_MULT);
        sup_mul = {10'b0, acc_reg} * (SUM_W+10)'(hapc_pkg::SUPPLY_MULT);
        if (channel_reg == hapc_pkg::CH_CURRENT)
        begin
            scaled_next = cur_mul[SUM_W+6:7];
        end
        else
        begin
            scaled_next = SUM_W'(sup_mul[SUM_W+9:16]);
        end

        div5_mul = {16'b0, scaled_reg} * (SUM_W+16)'(hapc_pkg::DIV5_RECIP);
        cur_wide = 32'(div5_mul[SUM_W+15:18]);
        sup_wide = 32'(scaled_reg);

        div125_mul = {14'b0, pprod_reg[15:3]} * 27'(hapc_pkg::DIV125_RECIP);
        power_wide = div125_mul[26:20];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            ki_reg     <= hapc_pkg::GAIN_RESET;
            kp_reg     <= hapc_pkg::GAIN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hapc_pkg::REG_TARGET: target_reg <= cfg_data[9:0];
                hapc_pkg::REG_KI:     ki_reg     <= cfg_data;
                hapc_pkg::REG_KP:     kp_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hapc_pkg::RING_SIZE; i++)
            begin
                ring_reg[i] <= '0;
            end
            pos_reg          <= '0;
            ch_pos_reg       <= hapc_pkg::CH_TIP;
            held_tip_reg     <= '0;
            integ_reg        <= '0;
            held_current_reg <= '0;
            held_supply_reg  <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                ring_reg[pos_reg] <= adc_sample;
                pos_reg           <= pos_next;
                ch_pos_reg        <= ch_pos_next;
            end
            if (cmd.pi_int)
            begin
                integ_reg <= integ_next;
            end
            if (cmd.scale && channel_reg == hapc_pkg::CH_TIP)
            begin
                held_tip_reg <= tip_next;
            end
            if (cmd.divide && channel_reg == hapc_pkg::CH_CURRENT)
            begin
                held_current_reg <= (cur_wide > 32'(hapc_pkg::CURRENT_MAX)) ?
                                    10'(hapc_pkg::CURRENT_MAX) : cur_wide[9:0];
            end
            if (cmd.divide && channel_reg == hapc_pkg::CH_SUPPLY)
            begin
                held_supply_reg <= (sup_wide > 32'(hapc_pkg::SUPPLY_MAX)) ?
                                   6'(hapc_pkg::SUPPLY_MAX) : sup_wide[5:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            adc_reg     <= adc_sample;
            board_reg   <= board_temperature;
            channel_reg <= ch_pos_reg;
        end
        if (cmd.pi_mul)
        begin
            prod_i_reg <= prod_i_next;
            prod_p_reg <= prod_p_next;
        end
        if (cmd.pi_out)
        begin
            drive_reg  <= drive_next;
            acc_reg    <= '0;
            rd_ptr_reg <= POS_W'(channel_reg);
            cnt_reg    <= '0;
        end
        if (cmd.acc_step)
        begin
            acc_reg    <= acc_next;
            rd_ptr_reg <= rd_ptr_reg + POS_W'(3);
            cnt_reg    <= cnt_reg + CNT_W'(1);
        end
        if (cmd.scale)
        begin
            scaled_reg <= scaled_next;
        end
        if (cmd.power_mul)
        begin
            pprod_reg <= {6'b0, held_current_reg} * {10'b0, held_supply_reg};
        end
        if (cmd.power_div)
        begin
            power_reg <= (power_wide > 7'(hapc_pkg::POWER_MAX)) ?
                         5'(hapc_pkg::POWER_MAX) : power_wide[4:0];
        end
        if (cmd.out_load)
        begin
            out_channel_reg <= channel_reg;
            out_drive_reg   <= drive_reg;
            out_tip_reg     <= held_tip_reg;
            out_current_reg <= held_current_reg;
            out_supply_reg  <= held_supply_reg;
            out_power_reg   <= power_reg;
        end
    end

    assign status.channel  = channel_reg;
    assign status.acc_last = (cnt_reg == CNT_W'(hapc_pkg::AVERAGE_DEPTH - 1));

    assign channel         = out_channel_reg;
    assign heater_drive    = out_drive_reg;
    assign tip_temperature = out_tip_reg;
    assign heater_current  = out_current_reg;
    assign supply_level    = out_supply_reg;
    assign heater_power    = out_power_reg;

endmodule

`default_nettype wire

/* rtl/hapc_controller.sv */
// ----------------------------------------------------------------------------
// hapc_controller
// Sequencer that steps one word through the datapath and runs the handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

`include "heater_adc_average_pi_control_assert.svh"

module hapc_controller (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire hapc_pkg::status_t status,
    output hapc_pkg::cmd_t         cmd
);

    hapc_pkg::state_t state_reg;
    hapc_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             accept;
    logic             out_free;

    assign in_stall = (state_reg != hapc_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hapc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = hapc_pkg::ST_PI_MUL;
                end
            end
            hapc_pkg::ST_PI_MUL:    state_next = hapc_pkg::ST_PI_INT;
            hapc_pkg::ST_PI_INT:    state_next = hapc_pkg::ST_PI_OUT;
            hapc_pkg::ST_PI_OUT:
            begin
                if (status.channel == hapc_pkg::CH_TIP)
                begin
                    state_next = hapc_pkg::ST_SCALE;
                end
                else
                begin
                    state_next = hapc_pkg::ST_SUM;
                end
            end
            hapc_pkg::ST_SUM:
            begin
                if (status.acc_last)
                begin
                    state_next = hapc_pkg::ST_SCALE;
                end
            end
            hapc_pkg::ST_SCALE:     state_next = hapc_pkg::ST_DIVIDE;
            hapc_pkg::ST_DIVIDE:    state_next = hapc_pkg::ST_POWER_MUL;
            hapc_pkg::ST_POWER_MUL: state_next = hapc_pkg::ST_POWER_DIV;
            hapc_pkg::ST_POWER_DIV: state_next = hapc_pkg::ST_FINISH;
            hapc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = hapc_pkg::ST_IDLE;
                end
            end
            default:                state_next = hapc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.pi_mul    = (state_reg == hapc_pkg::ST_PI_MUL);
        cmd.pi_int    = (state_reg == hapc_pkg::ST_PI_INT);
        cmd.pi_out    = (state_reg == hapc_pkg::ST_PI_OUT);
        cmd.acc_step  = (state_reg == hapc_pkg::ST_SUM);
        cmd.scale     = (state_reg == hapc_pkg::ST_SCALE);
        cmd.divide    = (state_reg == hapc_pkg::ST_DIVIDE);
        cmd.power_mul = (state_reg == hapc_pkg::ST_POWER_MUL);
        cmd.power_div = (state_reg == hapc_pkg::ST_POWER_DIV);
        cmd.out_load  = (state_reg == hapc_pkg::ST_FINISH) && out_free;
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hapc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `HAPC_ASSERT_NEXT(a_accept_starts_pi, clk, rst_n, accept, state_reg == hapc_pkg::ST_PI_MUL)
    `HAPC_ASSERT_NEXT(a_sum_runs_to_end, clk, rst_n, state_reg == hapc_pkg::ST_SUM && !status.acc_last, state_reg == hapc_pkg::ST_SUM)
    `HAPC_ASSERT_SAME(a_load_only_when_free, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall)
    `HAPC_ASSERT_NEXT(a_load_raises_valid, clk, rst_n, cmd.out_load, out_valid_reg && state_reg == hapc_pkg::ST_IDLE)

endmodule

`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for heater_adc_average_pi_control
// Feeds ADC words with board temperatures through a valid/stall channel and
// checks every result word against a cycle-free model of the averaging front
// end and the saturating PI loop, under several gain and setpoint settings.
// ----------------------------------------------------------------------------
module tb;
    import hapc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    localparam longint I32_MAX = 2147483647;
    localparam longint I32_MIN = -I32_MAX - 1;
    localparam longint D24_MAX = 8388607;
    localparam longint D24_MIN = -8388608;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_AFTER = 160;
    localparam int HOLD_CYCLES = 150;

    typedef struct packed {
        logic [9:0]        adc;
        logic signed [7:0] board;
    } adc_word_t;

    typedef struct packed {
        channel_t           channel;
        logic signed [23:0] drive;
        logic signed [11:0] tip;
        logic [9:0]         current;
        logic [5:0]         supply;
        logic [4:0]         power;
    } control_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [9:0] adc_sample = '0;
    logic signed [7:0] board_temperature = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] channel;
    logic signed [23:0] heater_drive;
    logic signed [11:0] tip_temperature;
    logic [9:0] heater_current;
    logic [5:0] supply_level;
    logic [4:0] heater_power;

    adc_word_t adc_words_pending[$];
    control_result_t results_expected[$];

    logic [9:0] model_ring [RING_SIZE] = '{default: '0};
    int model_pos = 0;
    int model_tip = 0;
    int model_integrator = 0;
    int model_current = 0;
    int model_supply = 0;
    int model_target = 0;
    int model_ki = 256;
    int model_kp = 256;

    int mismatches = 0;
    int results_seen = 0;
    int cycle_count;
    bit gapless = 1'b0;
    int tx_gap = 0;
    int rx_wait = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    heater_adc_average_pi_control i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .adc_sample       (adc_sample),
        .board_temperature(board_temperature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .channel          (channel),
        .heater_drive     (heater_drive),
        .tip_temperature  (tip_temperature),
        .heater_current   (heater_current),
        .supply_level     (supply_level),
        .heater_power     (heater_power)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic control_result_t predict_control(logic [9:0] adc,
                                                        logic signed [7:0] board);
        control_result_t r;
        channel_t ch;
        longint err;
        longint drive;
        int slot;
        int sum;
        int k;
        err = longint'(model_target) - longint'(model_tip);
        model_integrator = int'(clamp(longint'(model_integrator) + longint'(model_ki) * err,
                                      I32_MIN, I32_MAX));
        drive = (longint'(model_integrator) + longint'(model_kp) * err) / 256;
        drive = clamp(drive, D24_MIN, D24_MAX);

        slot = model_pos;
        model_ring[slot] = adc;
        ch = channel_t'(slot % 3);
        sum = 0;
        for (k = 0; k < AVERAGE_DEPTH; k++)
        begin
            sum += int'(model_ring[int'(ch) + 3 * k]);
        end
        case (ch)
            CH_TIP:
            begin
                model_tip = (int'(adc) * 113) / 128 + int'(board);
            end
            CH_CURRENT:
            begin
                model_current = int'(clamp(sum * 113 / 640, 0, 1023));
            end
            default:
            begin
                model_supply = int'(clamp((sum * 629) / 65536, 0, 63));
            end
        endcase
        model_pos = (slot + 1) % RING_SIZE;

        r.channel = ch;
        r.drive = 24'(drive);
        r.tip = 12'(model_tip);
        r.current = 10'(model_current);
        r.supply = 6'(model_supply);
        r.power = 5'(clamp(model_current * model_supply / 1000, 0, 31));
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : send_words
        adc_word_t w;
        logic took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                results_expected.push_back(predict_control(adc_sample, board_temperature));
                tx_gap = gapless ? 0 : $urandom_range(0, 3);
            end
            if (took || !in_valid)
            begin
                if (tx_gap == 0 && adc_words_pending.size() != 0)
                begin
                    w = adc_words_pending.pop_front();
                    adc_sample <= w.adc;
                    board_temperature <= w.board;
                    in_valid <= 1'b1;
                end
                else
                begin
                    if (tx_gap > 0)
                    begin
                        tx_gap--;
                    end
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : receive_words
        control_result_t want;
        logic took;
        took = rst_n && out_valid && !out_stall;
        if (took)
        begin
            results_seen++;
            if (results_expected.size() == 0)
            begin
                $error("result word arrived with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = results_expected.pop_front();
                check_field("channel", want.channel, channel);
                check_field("heater_drive", want.drive, heater_drive);
                check_field("tip_temperature", want.tip, tip_temperature);
                check_field("heater_current", want.current, heater_current);
                check_field("supply_level", want.supply, supply_level);
                check_field("heater_power", want.power, heater_power);
            end
        end
        // Hold the output off once for a long stretch so the block backs up.
        if (!hold_done && results_seen == HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (took)
        begin
            rx_wait = gapless ? 0 : $urandom_range(0, 3);
            out_stall <= (rx_wait != 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_stall <= (rx_wait != 0);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    task automatic wait_until_drained();
        @(negedge clk);
        while (adc_words_pending.size() != 0 || in_valid || results_expected.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [15:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        case (index)
            REG_TARGET:
            begin
                model_target = int'(data[9:0]);
            end
            REG_KI:
            begin
                model_ki = int'(data);
            end
            REG_KP:
            begin
                model_kp = int'(data);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic run_phase(int target, int ki, int kp, int count,
                             int adc_lo, int adc_hi, bit burst);
        adc_word_t w;
        logic [15:0] data;
        int n;
        data = 16'($urandom);
        data[9:0] = 10'(target);
        write_register(REG_TARGET, data);
        write_register(REG_KI, 16'(ki));
        write_register(REG_KP, 16'(kp));
        write_register(REG_UNUSED, 16'($urandom));
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        gapless = burst;
        for (n = 0; n < count; n++)
        begin
            w.adc = 10'($urandom_range(adc_lo, adc_hi));
            w.board = 8'($urandom_range(0, 255));
            adc_words_pending.push_back(w);
        end
        wait_until_drained();
    endtask

    initial
    begin : stimulus
        logic [9:0] d_adc [24] = '{
            0, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023,
            341, 682, 0, 0, 0, 0, 682, 341, 512, 1, 0, 1023};
        logic signed [7:0] d_board [24] = '{
            -128, 127, 0, 127, -1, -55, 125, 85, -86, -128, 0, 1,
            85, -86, -1, -55, 125, 0, 1, -128, 127, 64, -64, 127};
        adc_word_t w;
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (n = 0; n < 24; n++)
        begin
            w.adc = d_adc[n];
            w.board = d_board[n];
            adc_words_pending.push_back(w);
        end
        wait_until_drained();

        run_phase(300, 256, 256, 64, 0, 1023, 1'b0);
        run_phase(1023, 65535, 65535, 60, 0, 100, 1'b1);
        run_phase(0, 65535, 65535, 50, 950, 1023, 1'b0);
        run_phase(0, 0, 0, 64, 0, 1023, 1'b0);
        run_phase($urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), 64, 0, 1023, 1'b1);
        run_phase($urandom_range(0, 1023), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), 64, 0, 1023, 1'b0);
        run_phase($urandom_range(0, 1023), $urandom_range(1, 16),
                  $urandom_range(0, 4096), 64, 0, 1023, 1'b0);

        repeat (20) @(posedge clk);
        if (mismatches == 0 && results_expected.size() == 0)
        begin
            $display("[heater_adc_average_pi_control] OK");
        end
        else
        begin
            $display("[heater_adc_average_pi_control] ERROR");
        end
        $finish;
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
        begin
            @(posedge clk);
        end
        $display("[heater_adc_average_pi_control] ERROR");
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/hapc_pkg.sv
rtl/hapc_datapath.sv
rtl/hapc_controller.sv
rtl/heater_adc_average_pi_control.sv
bench/tb.sv
